### hdl/fbilq_pkg.sv
`timescale 1ns / 1ps

package fbilq_pkg;

	// Default store depth
	localparam int DEPTH_DEF = 64;

	// Word width of stored elements and result data
	localparam int WORD_W = 32;
	localparam int CMD_W  = 3;
	localparam int STAT_W = 2;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_EMPTY     = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PEEK      = 3'd1;
	localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP       = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DUMP      = 3'd4;
	localparam logic [CMD_W-1:0] CMD_INS_BACK  = 3'd5;

	// Result status codes
	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

	// Data returned with an empty status
	localparam logic [WORD_W-1:0] DATA_NONE = '1;

endpackage

### hdl/front_back_insert_list_queue.sv
`timescale 1ns / 1ps

// Output-restricted deque of signed 32-bit words held in a circular buffer of
// DEPTH entries in one synchronous RAM. Words are inserted at the front (cmd 2)
// or the back (cmd 5) and removed only from the front (cmd 3); cmd 0 asks for
// emptiness, cmd 1 peeks the front, cmd 4 dumps every word front to back with
// tlast on the back word. Commands 6 and 7 are dropped. Inserts, the empty
// query, refused inserts, the dropped commands and any command on an empty list
// finish straight from the command; peek, pop and each dumped word wait for
// the registered read of the RAM, one read in flight at a time, and a stall
// on the output holds a dump between words. A new command is taken once the
// sequencer is idle and the output register is free or draining. The RAM is
// not cleared after reset: only entries written by an insert are ever read.
module front_back_insert_list_queue
	import fbilq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [31:0]       s_axis_tdata,   // [31:0] value
	input  logic [CMD_W-1:0]  s_axis_tuser,   // [2:0] cmd
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [31:0]       m_axis_tdata,   // [31:0] data
	output logic [STAT_W-1:0] m_axis_tuser,   // [1:0] status
	output logic              m_axis_tlast
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] IDX_MAX  = AW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
	localparam logic [CW:0]   SUM_WRAP = (CW + 1)'(DEPTH);

	// Sequencer states
	localparam logic [1:0] S_IDLE    = 2'd0;
	localparam logic [1:0] S_READ    = 2'd1;
	localparam logic [1:0] S_DUMP_RD = 2'd2;
	localparam logic [1:0] S_DUMP_WT = 2'd3;

	logic [1:0]        state_q;
	logic [AW-1:0]     front_q;
	logic [CW-1:0]     count_q;
	logic [AW-1:0]     dump_addr_q;
	logic [CW-1:0]     dump_left_q;
	logic              dump_last_q;

	logic              out_valid_q;
	logic [WORD_W-1:0] out_data_q;
	logic [STAT_W-1:0] out_stat_q;
	logic              out_last_q;

	logic              accept;
	logic              out_free;
	logic              empty;
	logic              full;
	logic [AW-1:0]     front_prev;
	logic [AW-1:0]     front_next;
	logic [AW-1:0]     dump_next;
	logic [CW:0]       back_sum;
	logic [AW-1:0]     back_addr;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [AW-1:0]     ram_raddr;
	logic [WORD_W-1:0] ram_rdata;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE) && out_free;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign empty         = (count_q == '0);
	assign full          = (count_q == CNT_FULL);

	// Wrap the front pointer and the dump pointer around the ring
	assign front_prev = (front_q == '0) ? IDX_MAX : front_q - 1'b1;
	assign front_next = (front_q == IDX_MAX) ? '0 : front_q + 1'b1;
	assign dump_next  = (dump_addr_q == IDX_MAX) ? '0 : dump_addr_q + 1'b1;

	// Back slot: front plus count, folded once below DEPTH
	assign back_sum  = {{(CW + 1 - AW){1'b0}}, front_q} + {1'b0, count_q};
	assign back_addr = (back_sum >= SUM_WRAP) ? AW'(back_sum - SUM_WRAP) : AW'(back_sum);

	// RAM port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = back_addr;
		if (accept && !full) begin
			if (s_axis_tuser == CMD_INS_FRONT) begin
				ram_we    = 1'b1;
				ram_waddr = front_prev;
			end else if (s_axis_tuser == CMD_INS_BACK) begin
				ram_we    = 1'b1;
			end
		end
		ram_raddr = (state_q == S_IDLE) ? front_q : dump_addr_q;
	end

	fbilq_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(s_axis_tdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Sequencer and list pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			front_q     <= '0;
			count_q     <= '0;
			dump_left_q <= '0;
			dump_last_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// drain the output word
			if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (s_axis_tuser)
							CMD_EMPTY: begin
								out_valid_q <= 1'b1;
							end
							CMD_PEEK: begin
								if (empty) begin
									out_valid_q <= 1'b1;
								end else begin
									state_q <= S_READ;
								end
							end
							CMD_POP: begin
								if (empty) begin
									out_valid_q <= 1'b1;
								end else begin
									state_q <= S_READ;
									front_q <= front_next;
									count_q <= count_q - 1'b1;
								end
							end
							CMD_DUMP: begin
								if (empty) begin
									out_valid_q <= 1'b1;
								end else begin
									state_q     <= S_DUMP_RD;
									dump_left_q <= count_q;
								end
							end
							CMD_INS_FRONT: begin
								if (full) begin
									out_valid_q <= 1'b1;
								end else begin
									front_q <= front_prev;
									count_q <= count_q + 1'b1;
								end
							end
							CMD_INS_BACK: begin
								if (full) begin
									out_valid_q <= 1'b1;
								end else begin
									count_q <= count_q + 1'b1;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_READ: begin
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_DUMP_RD: begin
					// issue one read once the output register can take it
					if (out_free) begin
						dump_left_q <= dump_left_q - 1'b1;
						dump_last_q <= (dump_left_q == CW'(1));
						state_q     <= S_DUMP_WT;
					end
				end
				S_DUMP_WT: begin
					out_valid_q <= 1'b1;
					state_q     <= dump_last_q ? S_IDLE : S_DUMP_RD;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output word and dump pointer
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			dump_addr_q <= front_q;
		end else if (state_q == S_DUMP_RD && out_free) begin
			dump_addr_q <= dump_next;
		end
		if (accept) begin
			out_last_q <= 1'b1;
			case (s_axis_tuser)
				CMD_EMPTY: begin
					out_data_q <= empty ? WORD_W'(1) : '0;
					out_stat_q <= STAT_OK;
				end
				CMD_INS_FRONT, CMD_INS_BACK: begin
					out_data_q <= '0;
					out_stat_q <= STAT_FULL;
				end
				default: begin
					out_data_q <= DATA_NONE;
					out_stat_q <= STAT_EMPTY;
				end
			endcase
		end else if (state_q == S_READ) begin
			out_data_q <= ram_rdata;
			out_stat_q <= STAT_OK;
			out_last_q <= 1'b1;
		end else if (state_q == S_DUMP_WT) begin
			out_data_q <= ram_rdata;
			out_stat_q <= STAT_OK;
			out_last_q <= dump_last_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_stat_q;
	assign m_axis_tlast  = out_last_q;

endmodule

### hdl/fbilq_ram.sv
`timescale 1ns / 1ps

module fbilq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one entry, read one entry with a registered output
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
